[rtl/bw1d_pkg.sv]
// Shared types and constants for the 1D blend-weight core.
package bw1d_pkg;

    localparam int unsigned MAX_POINTS = 8;
    localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned VAL_W      = 16;
    localparam int unsigned WGT_W      = 16;
    localparam int unsigned FRAC_W     = 15;
    localparam int unsigned STEP_W     = $clog2(FRAC_W + 1);

    localparam logic [WGT_W-1:0] ONE_Q15  = WGT_W'(32768);
    localparam logic [WGT_W-1:0] ZERO_Q15 = '0;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [2:0]              point_index;
        logic signed [VAL_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [2:0]       weight_index;
        logic [WGT_W-1:0] weight;
        logic             last;
        logic             no_points;
    } out_t;

endpackage

[rtl/blend_weights_1d_core.sv]
// Top level of the 1D piecewise-linear blend-weight core.
//
//  channel   signals                  handshake
//  -------   ----------------------   -----------------------------------
//  command   start, busy, cmd         beat taken when start && !busy
//  result    strobe, result           one beat per strobe cycle, no stall
//  config    cfg_we, cfg_data         point_count written when cfg_we
//
// A point write is taken in the idle state and leaves the core idle. An
// evaluation first loads and clamps the input value, then handles each of up
// to eight points in turn, running the serial divider where the weight is
// fractional; the divider produces one quotient bit per cycle. No point in use
// gives one beat in the cycle after the command. Reset clears control state and
// point_count; the point table holds garbage until written. Results cannot be stalled.
module blend_weights_1d_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bw1d_pkg::in_t        cmd,
    input  logic                 cfg_we,
    input  logic [3:0]           cfg_data,
    output logic                 strobe,
    output bw1d_pkg::out_t       result
);
    import bw1d_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_LAST,
        S_CLAMP,
        S_RD_PI,
        S_RD_PN,
        S_EVAL,
        S_PREP,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        pc_reg;
    logic [IDX_W-1:0]        cnt_m1_reg;
    logic signed [VAL_W-1:0] v_reg;
    logic signed [VAL_W-1:0] b_reg;
    logic                    low_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [VAL_W-1:0] pi_reg;
    logic                    ge_reg;
    logic signed [VAL_W:0]   num_reg;
    logic signed [VAL_W:0]   den_reg;
    logic [WGT_W-1:0]        w_reg;
    logic                    strobe_reg;
    out_t                    result_reg;
    logic                    div_start_reg;

    logic [VAL_W-1:0]        point_mem [MAX_POINTS];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;

    logic                    accept;
    logic [CNT_W-1:0]        eff_cnt;
    logic                    ge;
    logic [VAL_W:0]          an_wide;
    logic [VAL_W:0]          ad_wide;
    logic                    div_done;
    logic [FRAC_W-1:0]       div_quot;

    assign accept  = start && (state_reg == S_IDLE);
    assign eff_cnt = (pc_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pc_reg;
    assign ge      = b_reg >= rd_data_reg;
    assign an_wide = num_reg[VAL_W] ? 17'(-num_reg) : 17'(num_reg);
    assign ad_wide = den_reg[VAL_W] ? 17'(-den_reg) : 17'(den_reg);

    always_comb
    begin
        case (state_reg)
            S_IDLE:    rd_addr = '0;
            S_LD_LAST: rd_addr = cnt_m1_reg;
            S_RD_PN:   rd_addr = ge ? idx_reg + IDX_W'(1) : idx_reg - IDX_W'(1);
            default:   rd_addr = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.func == FUNC_WRITE)
        begin
            point_mem[cmd.point_index[IDX_W-1:0]] <= cmd.value;
        end
        rd_data_reg <= point_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else if (cfg_we)
        begin
            pc_reg <= cfg_data;
        end
    end

    bw1d_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (an_wide[VAL_W-1:0]),
        .den   (ad_wide[VAL_W-1:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_m1_reg    <= '0;
            v_reg         <= '0;
            b_reg         <= '0;
            low_reg       <= 1'b0;
            idx_reg       <= '0;
            pi_reg        <= '0;
            ge_reg        <= 1'b0;
            num_reg       <= '0;
            den_reg       <= '0;
            w_reg         <= '0;
            strobe_reg    <= 1'b0;
            result_reg    <= '0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            strobe_reg    <= 1'b0;
            div_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && cmd.func == FUNC_EVAL)
                    begin
                        if (eff_cnt == '0)
                        begin
                            result_reg.weight_index <= '0;
                            result_reg.weight       <= ZERO_Q15;
                            result_reg.last         <= 1'b1;
                            result_reg.no_points    <= 1'b1;
                            strobe_reg              <= 1'b1;
                        end
                        else
                        begin
                            cnt_m1_reg <= IDX_W'(eff_cnt - CNT_W'(1));
                            v_reg      <= cmd.value;
                            state_reg  <= S_LD_LAST;
                        end
                    end
                end
                S_LD_LAST:
                begin
                    if (v_reg < rd_data_reg)
                    begin
                        b_reg   <= rd_data_reg;
                        low_reg <= 1'b1;
                    end
                    else
                    begin
                        b_reg   <= v_reg;
                        low_reg <= 1'b0;
                    end
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    if (!low_reg && v_reg > rd_data_reg)
                    begin
                        b_reg <= rd_data_reg;
                    end
                    idx_reg <= '0;
                    if (cnt_m1_reg == '0)
                    begin
                        w_reg     <= ONE_Q15;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_RD_PI;
                    end
                end
                S_RD_PI:
                begin
                    state_reg <= S_RD_PN;
                end
                S_RD_PN:
                begin
                    pi_reg <= rd_data_reg;
                    ge_reg <= ge;
                    if ((ge && idx_reg == cnt_m1_reg) || (!ge && idx_reg == '0))
                    begin
                        w_reg     <= ONE_Q15;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (ge_reg ? (rd_data_reg < b_reg) : (rd_data_reg > b_reg))
                    begin
                        w_reg     <= ZERO_Q15;
                        state_reg <= S_EMIT;
                    end
                    else if (pi_reg == rd_data_reg)
                    begin
                        w_reg     <= ONE_Q15;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        num_reg   <= 17'(b_reg) - 17'(rd_data_reg);
                        den_reg   <= 17'(pi_reg) - 17'(rd_data_reg);
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (num_reg == '0 || num_reg[VAL_W] != den_reg[VAL_W])
                    begin
                        w_reg     <= ZERO_Q15;
                        state_reg <= S_EMIT;
                    end
                    else if (an_wide >= ad_wide)
                    begin
                        w_reg     <= ONE_Q15;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        w_reg     <= {1'b0, div_quot};
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    result_reg.weight_index <= 3'(idx_reg);
                    result_reg.weight       <= w_reg;
                    result_reg.last         <= (idx_reg == cnt_m1_reg);
                    result_reg.no_points    <= 1'b0;
                    strobe_reg              <= 1'b1;
                    if (idx_reg == cnt_m1_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_RD_PI;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

[rtl/bw1d_div.sv]
// Bit-serial restoring divider: fractional quotient num/den, one bit per cycle.
module bw1d_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bw1d_pkg::VAL_W-1:0]   num,
    input  logic [bw1d_pkg::VAL_W-1:0]   den,
    output logic                         done,
    output logic [bw1d_pkg::FRAC_W-1:0]  quot
);
    import bw1d_pkg::*;

    logic                run_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [VAL_W-1:0]    rem_reg;
    logic [VAL_W-1:0]    den_reg;
    logic [FRAC_W-1:0]   q_reg;
    logic [VAL_W:0]      shifted;
    logic [VAL_W:0]      diff;
    logic                fits;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(FRAC_W);
                rem_reg  <= num;
                den_reg  <= den;
                q_reg    <= '0;
            end
            else if (run_reg)
            begin
                q_reg    <= {q_reg[FRAC_W-2:0], fits};
                rem_reg  <= fits ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[rtl/bw1d_chk.sv]
// Port-level assertions for the blend-weight core, bound to the top level.
module bw1d_chk (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  bw1d_pkg::in_t        cmd,
    input  logic                 strobe,
    input  bw1d_pkg::out_t       result
);
    import bw1d_pkg::*;

    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.no_points |->
            result.last && result.weight == ZERO_Q15 && result.weight_index == '0)
        else $error("empty result beat malformed");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> result.weight <= ONE_Q15)
        else $error("weight above one");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.func == FUNC_WRITE |=> !busy && !strobe)
        else $error("point write caused activity");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("idle inside an evaluation");

    a_beat_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> !strobe)
        else $error("back-to-back beats inside an evaluation");

endmodule

bind blend_weights_1d_core bw1d_chk u_bw1d_chk (.*);
